/* design/etq_pkg.sv */
// ----------------------------------------------------------------------------
// etq_pkg
// Shared types, constants and the CORDIC arctangent table for the
// Euler-angle to quaternion converter.
// ----------------------------------------------------------------------------
package etq_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int LANES        = 3;

   // CORDIC datapath word: Q30 with headroom
   typedef logic signed [32:0] cw_type;
   // full-precision product
   typedef logic signed [63:0] pw_type;
   // angle and component words
   typedef logic signed [15:0] hw_type;

   localparam hw_type ANGLE_MAX = 16'sd25736;
   localparam hw_type Q14_ONE   = 16'sd16384;
   localparam cw_type GAIN_Q30  = 33'sd652032874;

   typedef struct packed {
      hw_type roll_angle;
      hw_type pitch_angle;
      hw_type yaw_angle;
   } req_word_type;

   typedef struct packed {
      hw_type w_part;
      hw_type x_part;
      hw_type y_part;
      hw_type z_part;
   } rsp_word_type;

   // rounded Q30 arctangent of 2^-i
   function automatic cw_type atan_q30(input int i);
      cw_type v;
      v = '0;
      case (i)
         0:  v = 33'sd843314857;
         1:  v = 33'sd497837829;
         2:  v = 33'sd263043837;
         3:  v = 33'sd133525159;
         4:  v = 33'sd67021687;
         5:  v = 33'sd33543516;
         6:  v = 33'sd16775851;
         7:  v = 33'sd8388437;
         8:  v = 33'sd4194283;
         9:  v = 33'sd2097149;
         10: v = 33'sd1048576;
         11: v = 33'sd524288;
         12: v = 33'sd262144;
         13: v = 33'sd131072;
         14: v = 33'sd65536;
         15: v = 33'sd32768;
         16: v = 33'sd16384;
         17: v = 33'sd8192;
         18: v = 33'sd4096;
         19: v = 33'sd2048;
         20: v = 33'sd1024;
         21: v = 33'sd512;
         22: v = 33'sd256;
         23: v = 33'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

/* design/etq_if.sv */
// ----------------------------------------------------------------------------
// etq_req_if / etq_rsp_if
// Valid/ready channels carrying angle words in and quaternion words out.
// ----------------------------------------------------------------------------
interface etq_req_if;
   logic            valid;
   logic            ready;
   etq_pkg::hw_type roll_angle;
   etq_pkg::hw_type pitch_angle;
   etq_pkg::hw_type yaw_angle;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

interface etq_rsp_if;
   logic            valid;
   logic            ready;
   etq_pkg::hw_type w_part;
   etq_pkg::hw_type x_part;
   etq_pkg::hw_type y_part;
   etq_pkg::hw_type z_part;
   modport source (output valid, w_part, x_part, y_part, z_part, input ready);
   modport sink   (input valid, w_part, x_part, y_part, z_part, output ready);
endinterface

/* design/euler_to_quaternion_core.sv */
// Registers in order: CORDIC stages, pair products, triple products, output word.
// Throughput: one word per cycle; the unrolled CORDIC lanes and the two
// multiply stages are fully pipelined, stalling only when the result is held.
// Reset: synchronous, active high; clears all stage valid bits.
// ----------------------------------------------------------------------------
// euler_to_quaternion_core
// Converts roll/pitch/yaw (Q3.13) to a unit quaternion (Q1.14) through three
// CORDIC lanes for the half-angle cosines and sines and a product pipeline.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core (
   input  logic         clock,
   input  logic         reset,
   etq_req_if.sink      req_bus,
   etq_rsp_if.source    rsp_bus
);

   localparam int NS = etq_pkg::CORDIC_STEPS;
   localparam int NL = etq_pkg::LANES;

   logic adv;

   etq_pkg::cw_type x_ff [NS+1][NL];
   etq_pkg::cw_type y_ff [NS+1][NL];
   etq_pkg::cw_type z_ff [NS+1][NL];
   etq_pkg::cw_type x_in [NS+1][NL];
   etq_pkg::cw_type y_in [NS+1][NL];
   etq_pkg::cw_type z_in [NS+1][NL];
   logic [NS:0]     cv_ff;

   etq_pkg::hw_type ang [NL];

   // pair products and carried yaw terms
   etq_pkg::pw_type p_ff [4];
   etq_pkg::pw_type p_in [4];
   etq_pkg::cw_type cy1_ff, sy1_ff;
   logic            v1_ff;

   // triple products
   etq_pkg::pw_type t_ff [8];
   etq_pkg::pw_type t_in [8];
   logic            v2_ff;

   etq_pkg::rsp_word_type out_ff, out_in;
   logic                  v3_ff;

   // advance the whole pipe unless the result is held
   assign adv           = !v3_ff || rsp_bus.ready;
   assign req_bus.ready = adv;

   // saturate angles to plus or minus pi
   always_comb begin
      ang[0] = req_bus.roll_angle;
      ang[1] = req_bus.pitch_angle;
      ang[2] = req_bus.yaw_angle;
      for (int l = 0; l < NL; l++) begin
         if (ang[l] > etq_pkg::ANGLE_MAX)  ang[l] = etq_pkg::ANGLE_MAX;
         if (ang[l] < -etq_pkg::ANGLE_MAX) ang[l] = -etq_pkg::ANGLE_MAX;
      end
   end

   // CORDIC rotation stages
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         x_in[0][l] = etq_pkg::GAIN_Q30;
         y_in[0][l] = '0;
         z_in[0][l] = {ang[l][15], ang[l], 16'h0000};
      end
      for (int s = 1; s <= NS; s++) begin
         for (int l = 0; l < NL; l++) begin
            if (!z_ff[s-1][l][32]) begin
               x_in[s][l] = x_ff[s-1][l] - (y_ff[s-1][l] >>> (s-1));
               y_in[s][l] = y_ff[s-1][l] + (x_ff[s-1][l] >>> (s-1));
               z_in[s][l] = z_ff[s-1][l] - etq_pkg::atan_q30(s-1);
            end else begin
               x_in[s][l] = x_ff[s-1][l] + (y_ff[s-1][l] >>> (s-1));
               y_in[s][l] = y_ff[s-1][l] - (x_ff[s-1][l] >>> (s-1));
               z_in[s][l] = z_ff[s-1][l] + etq_pkg::atan_q30(s-1);
            end
         end
      end
   end

   // pair products of roll and pitch
   always_comb begin
      logic signed [65:0] m [4];
      m[0] = x_ff[NS][0] * x_ff[NS][1];   // cr*cp
      m[1] = y_ff[NS][0] * y_ff[NS][1];   // sr*sp
      m[2] = y_ff[NS][0] * x_ff[NS][1];   // sr*cp
      m[3] = x_ff[NS][0] * y_ff[NS][1];   // cr*sp
      for (int k = 0; k < 4; k++) p_in[k] = m[k][63:0];
   end

   // round pairs to Q30 and multiply by yaw terms
   always_comb begin
      logic signed [33:0] r [4];
      logic signed [66:0] m [8];
      for (int k = 0; k < 4; k++) begin
         r[k] = 34'((p_ff[k] + 64'sd536870912) >>> 30);
      end
      m[0] = r[0] * cy1_ff;  m[1] = r[1] * sy1_ff;   // w
      m[2] = r[2] * cy1_ff;  m[3] = r[3] * sy1_ff;   // x
      m[4] = r[3] * cy1_ff;  m[5] = r[2] * sy1_ff;   // y
      m[6] = r[0] * sy1_ff;  m[7] = r[1] * cy1_ff;   // z
      for (int k = 0; k < 8; k++) t_in[k] = m[k][63:0];
   end

   // sum, round to Q14 and saturate
   always_comb begin
      etq_pkg::pw_type sm [4];
      etq_pkg::pw_type rs [4];
      etq_pkg::hw_type q  [4];
      sm[0] = t_ff[0] + t_ff[1];
      sm[1] = t_ff[2] - t_ff[3];
      sm[2] = t_ff[4] + t_ff[5];
      sm[3] = t_ff[6] - t_ff[7];
      for (int k = 0; k < 4; k++) begin
         rs[k] = (sm[k] + 64'sh0000_2000_0000_0000) >>> 46;
         if (rs[k] > 64'(etq_pkg::Q14_ONE))       q[k] = etq_pkg::Q14_ONE;
         else if (rs[k] < -64'(etq_pkg::Q14_ONE)) q[k] = -etq_pkg::Q14_ONE;
         else                                      q[k] = rs[k][15:0];
      end
      out_in.w_part = q[0];
      out_in.x_part = q[1];
      out_in.y_part = q[2];
      out_in.z_part = q[3];
   end

   // advance payload registers
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         z_ff   <= z_in;
         p_ff   <= p_in;
         cy1_ff <= x_ff[NS][2];
         sy1_ff <= y_ff[NS][2];
         t_ff   <= t_in;
         out_ff <= out_in;
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         cv_ff <= {cv_ff[NS-1:0], req_bus.valid};
         v1_ff <= cv_ff[NS];
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign rsp_bus.valid  = v3_ff;
   assign rsp_bus.w_part = out_ff.w_part;
   assign rsp_bus.x_part = out_ff.x_part;
   assign rsp_bus.y_part = out_ff.y_part;
   assign rsp_bus.z_part = out_ff.z_part;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives attitude words (roll, pitch, yaw) into the Euler-to-quaternion core
// and checks every quaternion word against a bit-exact CORDIC predictor.
// Directed extremes and saturation cases come first, then random words under
// bursty sending and a patterned receiver stall.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_LEN  = 24;
   localparam int IDLE_LIMIT = 5000;
   localparam int N_RANDOM   = 800;

   logic clock;
   logic reset;
   int   fail_count;
   int   sent_count;
   int   checked_count;
   int   idle_cycles;
   int   stall_phase;
   bit   stim_done;

   etq_pkg::rsp_word_type quat_expected[$];

   etq_req_if req_bus ();
   etq_rsp_if rsp_bus ();

   euler_to_quaternion_core DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // arctangent table in Q30, local copy
   function automatic longint arctan_step(input int i);
      longint tbl[TABLE_LEN] = '{
         843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
         16775851, 8388437, 4194283, 2097149, 1048576, 524288,
         262144, 131072, 65536, 32768, 16384, 8192,
         4096, 2048, 1024, 512, 256, 128};
      return tbl[i];
   endfunction

   // clamp an angle code to plus or minus pi
   function automatic longint clamp_angle(input etq_pkg::hw_type raw);
      longint a;
      a = raw;
      if (a > 25736) a = 25736;
      if (a < -25736) a = -25736;
      return a;
   endfunction

   // rotation-mode CORDIC on the half angle
   task automatic half_angle_trig(input etq_pkg::hw_type raw,
                                  output longint c, output longint s);
      longint x, y, z, dx, dy;
      x = 652032874;
      y = 0;
      z = clamp_angle(raw) * 65536;
      for (int i = 0; i < etq_pkg::CORDIC_STEPS && i < TABLE_LEN; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= arctan_step(i);
         end else begin
            x += dx; y -= dy; z += arctan_step(i);
         end
      end
      c = x;
      s = y;
   endtask

   function automatic longint round_q30(input longint v);
      return (v + (64'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic etq_pkg::hw_type to_component(input longint v60);
      longint r;
      r = (v60 + (64'sd1 <<< 45)) >>> 46;
      if (r > 16384) r = 16384;
      if (r < -16384) r = -16384;
      return etq_pkg::hw_type'(r);
   endfunction

   task automatic predict_quaternion(input etq_pkg::req_word_type a,
                                     output etq_pkg::rsp_word_type q);
      longint cr, sr, cp, sp, cy, sy, crcp, srsp, srcp, crsp;
      half_angle_trig(a.roll_angle, cr, sr);
      half_angle_trig(a.pitch_angle, cp, sp);
      half_angle_trig(a.yaw_angle, cy, sy);
      crcp = round_q30(cr * cp);
      srsp = round_q30(sr * sp);
      srcp = round_q30(sr * cp);
      crsp = round_q30(cr * sp);
      q.w_part = to_component(crcp * cy + srsp * sy);
      q.x_part = to_component(srcp * cy - crsp * sy);
      q.y_part = to_component(crsp * cy + srcp * sy);
      q.z_part = to_component(crcp * sy - srsp * cy);
   endtask

   // send one word; hold valid until accepted
   task automatic send_angles(input etq_pkg::hw_type r, input etq_pkg::hw_type p,
                              input etq_pkg::hw_type y);
      etq_pkg::req_word_type a;
      etq_pkg::rsp_word_type q;
      a = '{roll_angle: r, pitch_angle: p, yaw_angle: y};
      req_bus.valid       <= 1'b1;
      req_bus.roll_angle  <= r;
      req_bus.pitch_angle <= p;
      req_bus.yaw_angle   <= y;
      do @(posedge clock); while (!req_bus.ready);
      predict_quaternion(a, q);
      quat_expected.push_back(q);
      sent_count++;
   endtask

   task automatic pause_sender(input int n);
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // random angle code across the full 16-bit range, mostly in range
   function automatic etq_pkg::hw_type random_angle();
      case ($urandom_range(0, 9))
         0: return etq_pkg::hw_type'($urandom);
         1: return etq_pkg::hw_type'($urandom_range(0, 40) - 20 +
                                     ($urandom_range(0, 1) ? 25736 : -25736));
         default: return etq_pkg::hw_type'(int'($urandom_range(0, 51472)) - 25736);
      endcase
   endfunction

   task automatic test_directed();
      etq_pkg::hw_type edges[9] = '{16'sd0, 16'sd1, -16'sd1, 16'sd25736, -16'sd25736,
                                    16'sd25737, -16'sd25737, 16'sh7FFF, 16'sh8000};
      for (int i = 0; i < 9; i++) send_angles(edges[i], edges[(i + 3) % 9], edges[(i + 6) % 9]);
      send_angles(16'sd12868, 16'sd0, 16'sd0);
      send_angles(16'sd0, 16'sd12868, 16'sd0);
      send_angles(16'sd0, 16'sd0, 16'sd12868);
      send_angles(-16'sd12868, 16'sd25736, -16'sd25736);
      send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
      send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);
      pause_sender(1);
   endtask

   task automatic test_random();
      int left;
      left = N_RANDOM;
      while (left > 0) begin
         int burst;
         burst = $urandom_range(1, 40);
         for (int i = 0; i < burst && left > 0; i++, left--)
            send_angles(random_angle(), random_angle(), random_angle());
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
      pause_sender(1);
   endtask

   // receiver stall pattern: long ready stretches, then on-off runs and a random stretch
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_phase   <= 0;
      end else begin
         stall_phase   <= (stall_phase + 1) % 97;
         rsp_bus.ready <= (stall_phase < 40) ? 1'b1 :
                          (stall_phase < 70) ? stall_phase[0] : ($urandom_range(0, 2) != 0);
      end
   end

   // compare each accepted quaternion word with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         etq_pkg::rsp_word_type want;
         if (quat_expected.size() == 0) begin
            $display("%0t unexpected word w=%0d x=%0d y=%0d z=%0d", $time,
                     rsp_bus.w_part, rsp_bus.x_part, rsp_bus.y_part, rsp_bus.z_part);
            fail_count++;
         end else begin
            want = quat_expected.pop_front();
            checked_count++;
            if (rsp_bus.w_part !== want.w_part) begin
               $display("%0t w_part expected %0d actual %0d", $time, want.w_part, rsp_bus.w_part);
               fail_count++;
            end
            if (rsp_bus.x_part !== want.x_part) begin
               $display("%0t x_part expected %0d actual %0d", $time, want.x_part, rsp_bus.x_part);
               fail_count++;
            end
            if (rsp_bus.y_part !== want.y_part) begin
               $display("%0t y_part expected %0d actual %0d", $time, want.y_part, rsp_bus.y_part);
               fail_count++;
            end
            if (rsp_bus.z_part !== want.z_part) begin
               $display("%0t z_part expected %0d actual %0d", $time, want.z_part, rsp_bus.z_part);
               fail_count++;
            end
         end
      end
   end

   // watchdog: end the run after too long without any word moving
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else if (!stim_done || quat_expected.size() != 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog expired, %0d words outstanding", $time, quat_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      fail_count          = 0;
      sent_count          = 0;
      checked_count       = 0;
      idle_cycles         = 0;
      stim_done           = 1'b0;
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.roll_angle  = '0;
      req_bus.pitch_angle = '0;
      req_bus.yaw_angle   = '0;
      rsp_bus.ready       = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      stim_done = 1'b1;
      while (quat_expected.size() != 0) @(posedge clock);
      repeat (etq_pkg::CORDIC_STEPS + 10) @(posedge clock);
      $display("Sent %0d attitude words, checked %0d quaternion words,", sent_count, checked_count);
      $display("including angle saturation, both signs and full-range codes.");
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
